// File: src/tsfr_pkg.sv
// Shared types and constants of the tone symbol frame receiver.
// No dependencies; used by every module under src.
package tsfr_pkg;

    localparam int SYM_W       = 5;
    localparam int DIGIT_W     = 4;
    localparam int CFG_W       = 7;
    localparam int CNT_W       = 7;
    localparam int DIGITS      = 16;
    localparam int ORDER_LEN   = 4;
    localparam int STOP_WINDOW = 4;
    localparam int TAIL_FILL_W = 3;

    localparam logic [CNT_W-1:0] CNT_MAX          = 7'd127;
    localparam logic [CFG_W-1:0] SLOT_FRAMES_INIT = 7'd12;

    typedef logic [DIGIT_W-1:0] digit_t;

    // Start order 1,5,9,D and stop order 2,*,B,D as nibble codes
    localparam digit_t START_ORDER [ORDER_LEN] = '{4'd0, 4'd5, 4'd10, 4'd15};
    localparam digit_t STOP_ORDER  [ORDER_LEN] = '{4'd1, 4'd12, 4'd7, 4'd15};

    typedef enum logic [1:0] {
        PH_SEARCH = 2'd0,
        PH_RECV   = 2'd1,
        PH_DONE   = 2'd2
    } phase_t;

    typedef enum logic {
        SEL_START = 1'b0,
        SEL_STOP  = 1'b1
    } order_sel_t;

    // Outcome of one tallied frame
    typedef struct packed {
        logic   slot_end;
        logic   emit;
        digit_t sym;
    } tally_res_t;

    // One result item, lowest field in the lowest bits
    typedef struct packed {
        logic [1:0] phase_now;
        logic       stop_seen;
        logic       start_seen;
        digit_t     emit_symbol;
        logic       emit_valid;
    } res_t;

endpackage

// File: src/tsfr_order_scan.sv
// Serial order checker: takes one symbol of a sequence per step, oldest first.
// Depends on tsfr_pkg for the start and stop orders.
module tsfr_order_scan (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           clear,
    input  logic                           step,
    input  tsfr_pkg::order_sel_t           sel,
    input  logic [tsfr_pkg::SYM_W-1:0]     sym,
    output logic                           pass
);

    localparam int PAIRS = tsfr_pkg::ORDER_LEN - 1;

    logic [PAIRS-1:0] have_last_reg, have_last_next;
    logic [PAIRS-1:0] have_first_reg, have_first_next;
    logic [PAIRS-1:0] bad_reg, bad_next;

    always_comb
    begin
        logic hit_a;
        logic hit_b;
        tsfr_pkg::digit_t a;
        tsfr_pkg::digit_t b;
        for (int p = 0; p < PAIRS; p++)
        begin
            a = (sel == tsfr_pkg::SEL_STOP) ? tsfr_pkg::STOP_ORDER[p]
                                            : tsfr_pkg::START_ORDER[p];
            b = (sel == tsfr_pkg::SEL_STOP) ? tsfr_pkg::STOP_ORDER[p+1]
                                            : tsfr_pkg::START_ORDER[p+1];
            hit_a = (sym == {1'b0, a});
            hit_b = (sym == {1'b0, b});
            have_last_next[p]  = have_last_reg[p] | hit_a;
            have_first_next[p] = have_first_reg[p] | hit_b;
            // first symbol seen again after the second one appeared
            bad_next[p]        = bad_reg[p] | (hit_a & have_first_reg[p]);
        end
    end

    assign pass = &(have_last_next & have_first_next & ~bad_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_last_reg  <= '0;
            have_first_reg <= '0;
            bad_reg        <= '0;
        end
        else if (clear)
        begin
            have_last_reg  <= '0;
            have_first_reg <= '0;
            bad_reg        <= '0;
        end
        else if (step)
        begin
            have_last_reg  <= have_last_next;
            have_first_reg <= have_first_next;
            bad_reg        <= bad_next;
        end
    end

endmodule

// File: src/tsfr_tally.sv
// Slot tally: per-digit counts, running best symbol and slot frame counter.
// Depends on tsfr_pkg for widths and the tally result struct.
module tsfr_tally #(
    parameter int SLOT_MAX = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           clear,
    input  logic [tsfr_pkg::SYM_W-1:0]     sym,
    input  logic [tsfr_pkg::CFG_W-1:0]     slot_frames,
    output tsfr_pkg::tally_res_t           res
);

    localparam int LIM_W = $clog2(SLOT_MAX + 1);
    localparam int CMP_W = (LIM_W > tsfr_pkg::CFG_W) ? LIM_W : tsfr_pkg::CFG_W;

    logic [tsfr_pkg::CNT_W-1:0] count_reg [tsfr_pkg::DIGITS];
    logic [tsfr_pkg::CNT_W-1:0] best_cnt_reg, best_cnt_next;
    tsfr_pkg::digit_t           best_sym_reg, best_sym_next;
    logic [LIM_W-1:0]           frame_reg;

    logic                       is_digit;
    logic [tsfr_pkg::CNT_W-1:0] cnt_cur;
    logic [tsfr_pkg::CNT_W-1:0] cnt_inc;
    logic [CMP_W-1:0]           sf_ext;
    logic [CMP_W-1:0]           limit;
    logic [CMP_W-1:0]           frame_inc;

    assign is_digit = ~sym[tsfr_pkg::SYM_W-1] ;
    assign cnt_cur  = count_reg[sym[tsfr_pkg::DIGIT_W-1:0]];
    assign cnt_inc  = (cnt_cur == tsfr_pkg::CNT_MAX) ? cnt_cur : cnt_cur + 1'b1;

    always_comb
    begin
        best_cnt_next = best_cnt_reg;
        best_sym_next = best_sym_reg;
        // strictly greater: on a tie the earlier leader stays
        if (is_digit && (cnt_inc > best_cnt_reg))
        begin
            best_cnt_next = cnt_inc;
            best_sym_next = sym[tsfr_pkg::DIGIT_W-1:0];
        end
    end

    assign sf_ext    = CMP_W'(slot_frames);
    assign limit     = (sf_ext == '0) ? CMP_W'(1)
                     : (sf_ext > CMP_W'(SLOT_MAX)) ? CMP_W'(SLOT_MAX) : sf_ext;
    assign frame_inc = CMP_W'(frame_reg) + CMP_W'(1);

    assign res.slot_end = (frame_inc >= limit);
    assign res.emit     = res.slot_end && (best_cnt_next != '0);
    assign res.sym      = best_sym_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tsfr_pkg::DIGITS; i++)
                count_reg[i] <= '0;
            best_cnt_reg <= '0;
            best_sym_reg <= '0;
            frame_reg    <= '0;
        end
        else if (clear || (en && res.slot_end))
        begin
            for (int i = 0; i < tsfr_pkg::DIGITS; i++)
                count_reg[i] <= '0;
            best_cnt_reg <= '0;
            best_sym_reg <= '0;
            frame_reg    <= '0;
        end
        else if (en)
        begin
            if (is_digit)
                count_reg[sym[tsfr_pkg::DIGIT_W-1:0]] <= cnt_inc;
            best_cnt_reg <= best_cnt_next;
            best_sym_reg <= best_sym_next;
            frame_reg    <= frame_inc[LIM_W-1:0];
        end
    end

endmodule

// File: src/tone_symbol_frame_receiver.sv
// Tone symbol receiver: searches for the start order, then emits the most frequent
// symbol of each slot until the stop order; an item is one frame's symbol, every
// request returns one result. An ordinary frame is accepted, then its result is
// loaded; while the search window is full each frame also passes through the
// serial order scan, which reads one window entry per cycle, and a slot emission
// with a full tail runs the same scan over the four emitted symbols. A waiting
// result stalls the receiver until the output side takes it. Depends on tsfr_pkg,
// tsfr_tally and tsfr_order_scan.
module tone_symbol_frame_receiver #(
    parameter int START_WINDOW = 30,
    parameter int SLOT_MAX     = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [4:0] tone_symbol
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [0] emit_valid, [4:1] emit_symbol,
                                        // [5] start_seen, [6] stop_seen, [8:7] phase_now
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data        // slot_frames
);

    localparam int FILL_W = $clog2(START_WINDOW + 1);
    localparam int SCAN_W = $clog2(START_WINDOW);
    localparam int RES_W  = $bits(tsfr_pkg::res_t);

    typedef enum logic [3:0] {
        ST_IDLE       = 4'b0001,
        ST_SCAN_START = 4'b0010,
        ST_SCAN_STOP  = 4'b0100,
        ST_WRITE      = 4'b1000
    } state_t;

    state_t                         state_reg, state_next;
    tsfr_pkg::phase_t               phase_reg, phase_next;
    logic [tsfr_pkg::CFG_W-1:0]     slot_frames_reg;
    logic [FILL_W-1:0]              fill_reg, fill_next;
    logic [tsfr_pkg::TAIL_FILL_W-1:0] tail_fill_reg, tail_fill_next;
    logic [SCAN_W-1:0]              scan_cnt_reg, scan_cnt_next;
    tsfr_pkg::res_t                 pend_reg, pend_next;
    tsfr_pkg::res_t                 out_reg;
    logic                           out_valid_reg;

    logic [tsfr_pkg::SYM_W-1:0]     win_reg  [START_WINDOW];
    tsfr_pkg::digit_t               tail_reg [tsfr_pkg::STOP_WINDOW];

    logic                           in_fire;
    logic [tsfr_pkg::SYM_W-1:0]     in_sym;
    logic                           out_free;
    logic                           win_shift, win_rotate;
    logic                           tail_shift, tail_rotate;
    logic                           scan_clear, scan_step;
    logic                           scan_pass;
    logic                           scan_last;
    tsfr_pkg::order_sel_t           scan_sel;
    logic [tsfr_pkg::SYM_W-1:0]     scan_sym;
    logic                           tally_en, tally_clear;
    tsfr_pkg::tally_res_t           tally_res;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign in_sym        = s_axis_tdata[tsfr_pkg::SYM_W-1:0];
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign cfg_ready     = 1'b1;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(16 - RES_W){1'b0}}, out_reg};

    assign scan_sel  = (state_reg == ST_SCAN_STOP) ? tsfr_pkg::SEL_STOP : tsfr_pkg::SEL_START;
    assign scan_sym  = (state_reg == ST_SCAN_STOP) ? {1'b0, tail_reg[0]} : win_reg[0];
    assign scan_step = (state_reg == ST_SCAN_START) || (state_reg == ST_SCAN_STOP);
    assign scan_last = (state_reg == ST_SCAN_STOP)
                     ? (scan_cnt_reg == SCAN_W'(tsfr_pkg::STOP_WINDOW - 1))
                     : (scan_cnt_reg == SCAN_W'(START_WINDOW - 1));
    assign win_rotate  = (state_reg == ST_SCAN_START);
    assign tail_rotate = (state_reg == ST_SCAN_STOP);

    assign tally_en = in_fire && (phase_reg == tsfr_pkg::PH_RECV);

    tsfr_tally #(
        .SLOT_MAX (SLOT_MAX)
    ) u_tally (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (tally_en),
        .clear       (tally_clear),
        .sym         (in_sym),
        .slot_frames (slot_frames_reg),
        .res         (tally_res)
    );

    tsfr_order_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (scan_clear),
        .step  (scan_step),
        .sel   (scan_sel),
        .sym   (scan_sym),
        .pass  (scan_pass)
    );

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        fill_next      = fill_reg;
        tail_fill_next = tail_fill_reg;
        scan_cnt_next  = scan_cnt_reg;
        pend_next      = pend_reg;
        win_shift      = 1'b0;
        tail_shift     = 1'b0;
        scan_clear     = 1'b0;
        tally_clear    = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    pend_next     = '0;
                    scan_cnt_next = '0;
                    scan_clear    = 1'b1;
                    state_next    = ST_WRITE;
                    unique case (phase_reg)
                        tsfr_pkg::PH_SEARCH:
                        begin
                            win_shift = 1'b1;
                            if (fill_reg != FILL_W'(START_WINDOW))
                                fill_next = fill_reg + 1'b1;
                            if (fill_next == FILL_W'(START_WINDOW))
                                state_next = ST_SCAN_START;
                        end
                        tsfr_pkg::PH_RECV:
                        begin
                            if (tally_res.emit)
                            begin
                                pend_next.emit_valid  = 1'b1;
                                pend_next.emit_symbol = tally_res.sym;
                                tail_shift            = 1'b1;
                                if (tail_fill_reg !=
                                    tsfr_pkg::TAIL_FILL_W'(tsfr_pkg::STOP_WINDOW))
                                    tail_fill_next = tail_fill_reg + 1'b1;
                                if (tail_fill_next ==
                                    tsfr_pkg::TAIL_FILL_W'(tsfr_pkg::STOP_WINDOW))
                                    state_next = ST_SCAN_STOP;
                            end
                        end
                        default:
                        begin
                            // finished: ignore the symbol
                        end
                    endcase
                end
            end
            ST_SCAN_START:
            begin
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (scan_last)
                begin
                    state_next = ST_WRITE;
                    if (scan_pass)
                    begin
                        pend_next.start_seen = 1'b1;
                        phase_next           = tsfr_pkg::PH_RECV;
                        tally_clear          = 1'b1;
                    end
                end
            end
            ST_SCAN_STOP:
            begin
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (scan_last)
                begin
                    state_next = ST_WRITE;
                    if (scan_pass)
                    begin
                        pend_next.stop_seen = 1'b1;
                        phase_next          = tsfr_pkg::PH_DONE;
                    end
                end
            end
            ST_WRITE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            phase_reg       <= tsfr_pkg::PH_SEARCH;
            slot_frames_reg <= tsfr_pkg::SLOT_FRAMES_INIT;
            fill_reg        <= '0;
            tail_fill_reg   <= '0;
            scan_cnt_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            fill_reg      <= fill_next;
            tail_fill_reg <= tail_fill_next;
            scan_cnt_reg  <= scan_cnt_next;
            if (cfg_valid && cfg_ready)
                slot_frames_reg <= cfg_data;
            if ((state_reg == ST_WRITE) && out_free)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload: pending result, output register, window and tail
    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        if ((state_reg == ST_WRITE) && out_free)
            out_reg <= tsfr_pkg::res_t'({phase_reg, pend_reg.stop_seen, pend_reg.start_seen,
                                         pend_reg.emit_symbol, pend_reg.emit_valid});
        // shift in the new symbol, or rotate the window under the scan
        if (win_shift || win_rotate)
        begin
            for (int i = 0; i < START_WINDOW - 1; i++)
                win_reg[i] <= win_reg[i+1];
            win_reg[START_WINDOW-1] <= win_shift ? in_sym : win_reg[0];
        end
        if (tail_shift || tail_rotate)
        begin
            for (int i = 0; i < tsfr_pkg::STOP_WINDOW - 1; i++)
                tail_reg[i] <= tail_reg[i+1];
            tail_reg[tsfr_pkg::STOP_WINDOW-1] <= tail_shift ? tally_res.sym : tail_reg[0];
        end
    end

endmodule
